// ----- rtl/dhtpwd_pkg.sv -----
// ----------------------------------------------------------------------------
// dhtpwd_pkg
// Shared types and constants for the single-wire pulse width decoder.
// ----------------------------------------------------------------------------
package dhtpwd_pkg;

	localparam int TICK_WIDTH_DEF = 32;
	localparam int TICK_IN_W      = 32;
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int BYTE_W         = 8;
	localparam int FRAME_BITS     = 40;
	localparam int BIT_CNT_W      = 6;

	localparam logic [CFG_W-1:0] SOF_MIN_RST = CFG_W'(80);
	localparam logic [CFG_W-1:0] ONE_MIN_RST = CFG_W'(60);
	localparam logic [CFG_W-1:0] ONE_MAX_RST = CFG_W'(80);

	localparam logic [BIT_CNT_W-1:0] FRAME_BITS_CNT = BIT_CNT_W'(FRAME_BITS);

	// request codes
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_EDGE  = 1'b1;

	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_READ = 2'd1,
		PH_DONE = 2'd3
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SOF_MIN = 2'd0,
		CFG_ONE_MIN = 2'd1,
		CFG_ONE_MAX = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] sof_min;
		logic [CFG_W-1:0] one_min;
		logic [CFG_W-1:0] one_max;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] temperature;
		logic [BYTE_W-1:0] humidity;
		logic              frame_done;
		logic              checksum_ok;
	} result_t;

endpackage

// ----- rtl/dhtpwd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// dhtpwd_cfg_regs
// Width threshold registers, written through a plain write port.
// ----------------------------------------------------------------------------
module dhtpwd_cfg_regs
	import dhtpwd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sof_min <= SOF_MIN_RST;
			cfg_q.one_min <= ONE_MIN_RST;
			cfg_q.one_max <= ONE_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SOF_MIN: cfg_q.sof_min <= cfg_wdata;
				CFG_ONE_MIN: cfg_q.one_min <= cfg_wdata;
				CFG_ONE_MAX: cfg_q.one_max <= cfg_wdata;
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/dhtpwd_frame.sv -----
// ----------------------------------------------------------------------------
// dhtpwd_frame
// Frame state: pulse width measurement, bit decode, checksum and data hold.
// ----------------------------------------------------------------------------
module dhtpwd_frame
	import dhtpwd_pkg::*;
#(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_en,
	input  logic                 req_type,
	input  logic                 pin_level,
	input  logic [TICK_IN_W-1:0] tick_now,
	input  cfg_t                 cfg,
	output result_t              result
);

	phase_t                  phase_q, phase_d;
	logic                    rise_seen_q, rise_seen_d;
	logic [TICK_WIDTH-1:0]   rise_tick_q, rise_tick_d;
	logic [BIT_CNT_W-1:0]    bit_count_q, bit_count_d;
	logic [FRAME_BITS-1:0]   frame_bits_q, frame_bits_d;
	logic [BYTE_W-1:0]       temp_hold_q, temp_hold_d;
	logic [BYTE_W-1:0]       humid_hold_q, humid_hold_d;

	logic [TICK_WIDTH-1:0]   tick_w;
	logic [TICK_WIDTH-1:0]   width;
	logic                    fall_evt;
	logic                    sof_hit;
	logic                    one_bit;
	logic [BIT_CNT_W-1:0]    bit_count_inc;
	logic                    last_bit;
	logic [FRAME_BITS-1:0]   frame_shift;
	logic [BYTE_W-1:0]       sum8;
	logic                    sum_match;

	// fit the incoming tick to the counter width
	generate
		if (TICK_WIDTH > TICK_IN_W) begin : g_ext
			assign tick_w = {{(TICK_WIDTH-TICK_IN_W){1'b0}}, tick_now};
		end else if (TICK_WIDTH == TICK_IN_W) begin : g_eq
			assign tick_w = tick_now;
		end else begin : g_trunc
			assign tick_w = tick_now[TICK_WIDTH-1:0];
		end
	endgenerate

	assign width    = tick_w - rise_tick_q;
	assign fall_evt = (req_type == REQ_EDGE) && rise_seen_q && !pin_level;
	assign sof_hit  = width > TICK_WIDTH'(cfg.sof_min);
	assign one_bit  = (width > TICK_WIDTH'(cfg.one_min)) && (width < TICK_WIDTH'(cfg.one_max));

	assign bit_count_inc = bit_count_q + BIT_CNT_W'(1);
	assign last_bit      = bit_count_inc >= FRAME_BITS_CNT;
	assign frame_shift   = {frame_bits_q[FRAME_BITS-2:0], one_bit};

	// checksum is the low byte of the sum of the four data bytes
	assign sum8 = frame_shift[39:32] + frame_shift[31:24] + frame_shift[23:16]
		+ frame_shift[15:8];
	assign sum_match = sum8 == frame_shift[7:0];

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (item_en) begin
			if (req_type == REQ_START) begin
				phase_d = PH_WAIT;
			end else if (fall_evt) begin
				case (phase_q)
					PH_WAIT: begin
						if (sof_hit) phase_d = PH_READ;
					end
					PH_READ: begin
						if (last_bit) phase_d = PH_DONE;
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	// datapath and result
	always_comb begin
		rise_seen_d  = rise_seen_q;
		rise_tick_d  = rise_tick_q;
		bit_count_d  = bit_count_q;
		frame_bits_d = frame_bits_q;
		temp_hold_d  = temp_hold_q;
		humid_hold_d = humid_hold_q;
		result.frame_done  = 1'b0;
		result.checksum_ok = 1'b0;
		if (req_type == REQ_START) begin
			rise_seen_d  = 1'b0;
			bit_count_d  = '0;
			frame_bits_d = '0;
		end else if (!rise_seen_q) begin
			if (pin_level) begin
				rise_tick_d = tick_w;
				rise_seen_d = 1'b1;
			end
		end else if (!pin_level) begin
			rise_seen_d = 1'b0;
			case (phase_q)
				PH_WAIT: begin
					if (sof_hit) bit_count_d = '0;
				end
				PH_READ: begin
					frame_bits_d = frame_shift;
					bit_count_d  = bit_count_inc;
					if (last_bit) begin
						result.frame_done = 1'b1;
						if (sum_match) begin
							result.checksum_ok = 1'b1;
							temp_hold_d  = frame_shift[23:16];
							humid_hold_d = frame_shift[39:32];
						end
					end
				end
				default: begin
					// done: widths are discarded
				end
			endcase
		end
		result.temperature = temp_hold_d;
		result.humidity    = humid_hold_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_DONE;
			rise_seen_q  <= 1'b0;
			rise_tick_q  <= '0;
			bit_count_q  <= '0;
			frame_bits_q <= '0;
			temp_hold_q  <= '0;
			humid_hold_q <= '0;
		end else if (item_en) begin
			phase_q      <= phase_d;
			rise_seen_q  <= rise_seen_d;
			rise_tick_q  <= rise_tick_d;
			bit_count_q  <= bit_count_d;
			frame_bits_q <= frame_bits_d;
			temp_hold_q  <= temp_hold_d;
			humid_hold_q <= humid_hold_d;
		end
	end

endmodule

// ----- rtl/dht11_pulse_width_decoder_top.sv -----
// ----------------------------------------------------------------------------
// dht11_pulse_width_decoder_top
// Single-wire sensor reply decoder driven by timestamped pin-edge words.
// ----------------------------------------------------------------------------
// Each input word is either a start request or a pin edge with its tick.
// One result word comes out per input word, through the input register and
// then the result register, and a new word is taken every cycle while the
// output side keeps up. The frame update between the two registers is one
// tick subtraction, three width compares, a shift and a four-byte add. The
// tick difference wraps modulo 2^TICK_WIDTH. The user must write threshold
// registers only while no word is in flight; the block does not enforce it.
module dht11_pulse_width_decoder_top
	import dhtpwd_pkg::*;
#(
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic                 pin_level,
	input  logic [TICK_IN_W-1:0] tick_now,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BYTE_W-1:0]    temperature,
	output logic [BYTE_W-1:0]    humidity,
	output logic                 frame_done,
	output logic                 checksum_ok,
	// configuration
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	cfg_t                 cfg;
	result_t              result;
	result_t              result_s2;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 req_type_s1;
	logic                 pin_level_s1;
	logic [TICK_IN_W-1:0] tick_now_s1;
	logic                 in_accept;
	logic                 adv_s1;

	assign adv_s1    = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_type_s1  <= req_type;
			pin_level_s1 <= pin_level;
			tick_now_s1  <= tick_now;
		end
	end

	dhtpwd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	dhtpwd_frame #(
		.TICK_WIDTH (TICK_WIDTH)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_en   (adv_s1),
		.req_type  (req_type_s1),
		.pin_level (pin_level_s1),
		.tick_now  (tick_now_s1),
		.cfg       (cfg),
		.result    (result)
	);

	// result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign temperature = result_s2.temperature;
	assign humidity    = result_s2.humidity;
	assign frame_done  = result_s2.frame_done;
	assign checksum_ok = result_s2.checksum_ok;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the single-wire pulse width decoder.
// ----------------------------------------------------------------------------
// Words go in as start requests and timestamped pin edges. Most random words
// form whole sensor replies: a start, a start-of-frame pulse, then forty bit
// pulses with a good or a broken checksum. The rest are truncated replies,
// repeated rises, lone falls, random noise and edges after a finished frame.
// The threshold registers change between phases, the extremes among them.
// An in-bench decoder predicts every result word, and the monitor compares
// each word field by field, in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
	import dhtpwd_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_WORDS = 215;

	typedef struct packed {
		logic                 req;
		logic                 level;
		logic [TICK_IN_W-1:0] tick;
	} pin_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 req_type = REQ_START;
	logic                 pin_level = 1'b0;
	logic [TICK_IN_W-1:0] tick_now = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [BYTE_W-1:0]    temperature;
	logic [BYTE_W-1:0]    humidity;
	logic                 frame_done;
	logic                 checksum_ok;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SOF_MIN;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	dht11_pulse_width_decoder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.pin_level   (pin_level),
		.tick_now    (tick_now),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.temperature (temperature),
		.humidity    (humidity),
		.frame_done  (frame_done),
		.checksum_ok (checksum_ok),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata)
	);

	always #10 clk = ~clk;

	// decoder state as the bench sees it
	cfg_t                    thresholds;
	phase_t                  dec_phase;
	logic                    dec_rise_seen;
	logic [TICK_IN_W-1:0]    dec_rise_tick;
	logic [BIT_CNT_W-1:0]    dec_bit_count;
	logic [FRAME_BITS-1:0]   dec_frame;
	logic [BYTE_W-1:0]       dec_temp;
	logic [BYTE_W-1:0]       dec_humid;

	pin_word_t   pending_words[$];
	result_t     expected_readings[$];
	pin_word_t   driven_word;
	result_t     want;
	result_t     got_word;
	bit          word_taken = 1'b0;
	bit          calm = 1'b0;
	int unsigned send_gap = 0;
	int unsigned stall_gap = 0;
	int unsigned idle_cycles = 0;
	int unsigned failures = 0;
	int unsigned pushed_words = 0;
	logic [TICK_IN_W-1:0] tick_cursor = '0;

	task automatic decode_word(input pin_word_t w, output result_t r);
		logic [TICK_IN_W-1:0] width;
		logic                 one_bit;
		logic [BYTE_W-1:0]    sum;
		r = '0;
		if (w.req == REQ_START) begin
			dec_phase = PH_WAIT;
			dec_rise_seen = 1'b0;
			dec_bit_count = '0;
			dec_frame = '0;
		end else if (!dec_rise_seen) begin
			if (w.level) begin
				dec_rise_tick = w.tick;
				dec_rise_seen = 1'b1;
			end
		end else if (!w.level) begin
			width = w.tick - dec_rise_tick;
			if (dec_phase == PH_WAIT) begin
				if (width > TICK_IN_W'(thresholds.sof_min)) begin
					dec_phase = PH_READ;
					dec_bit_count = '0;
				end
			end else if (dec_phase == PH_READ) begin
				one_bit = (width > TICK_IN_W'(thresholds.one_min)) &&
					(width < TICK_IN_W'(thresholds.one_max));
				dec_frame = {dec_frame[FRAME_BITS-2:0], one_bit};
				dec_bit_count = dec_bit_count + 1'b1;
				if (dec_bit_count >= FRAME_BITS_CNT) begin
					sum = dec_frame[39:32] + dec_frame[31:24] + dec_frame[23:16] +
						dec_frame[15:8];
					r.frame_done = 1'b1;
					if (sum == dec_frame[7:0]) begin
						r.checksum_ok = 1'b1;
						dec_temp = dec_frame[23:16];
						dec_humid = dec_frame[39:32];
					end
					dec_phase = PH_DONE;
				end
			end
			dec_rise_seen = 1'b0;
		end
		r.temperature = dec_temp;
		r.humidity = dec_humid;
	endtask

	function automatic void report_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			failures++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endfunction

	// driver: load the next word once the current one is taken
	always @(negedge clk) begin
		if (!in_valid || word_taken) begin
			word_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				driven_word = pending_words.pop_front();
				in_valid <= 1'b1;
				req_type <= driven_word.req;
				pin_level <= driven_word.level;
				tick_now <= driven_word.tick;
				send_gap = calm ? 0 : $urandom_range(0, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			decode_word(driven_word, want);
			expected_readings.push_back(want);
			word_taken = 1'b1;
		end
	end

	// monitor
	always @(negedge clk) begin
		if (stall_gap > 0) begin
			stall_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				failures++;
				$display("%0t: result word with nothing expected, actual t=%0d h=%0d done=%0b ok=%0b",
					$time, temperature, humidity, frame_done, checksum_ok);
			end else begin
				got_word = expected_readings.pop_front();
				report_field("temperature", got_word.temperature, temperature);
				report_field("humidity", got_word.humidity, humidity);
				report_field("frame_done", got_word.frame_done, frame_done);
				report_field("checksum_ok", got_word.checksum_ok, checksum_ok);
			end
			stall_gap = calm ? 0 : $urandom_range(0, 3);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("dht11_pulse_width_decoder_top verification failed");
			$finish;
		end
	end

	task automatic push_word(input logic req, input logic level, input logic [TICK_IN_W-1:0] tick);
		pin_word_t w;
		w.req = req;
		w.level = level;
		w.tick = tick;
		pending_words.push_back(w);
		pushed_words++;
	endtask

	function automatic logic [TICK_IN_W-1:0] zero_width();
		int unsigned lo;
		int unsigned hi;
		lo = thresholds.one_min;
		hi = thresholds.one_max;
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, lo);
			1: return lo;
			2: return hi;
			3: return hi + $urandom_range(0, 1000);
			default: return $urandom_range(32'h0010_0000, 32'hFFFF_FFFF);
		endcase
	endfunction

	function automatic logic [TICK_IN_W-1:0] one_width();
		int unsigned lo;
		int unsigned hi;
		lo = thresholds.one_min;
		hi = thresholds.one_max;
		if (hi < lo + 2)
			return zero_width();
		case ($urandom_range(0, 2))
			0: return lo + 1;
			1: return hi - 1;
			default: return $urandom_range(lo + 1, hi - 1);
		endcase
	endfunction

	// high pulse; a glitch adds a repeated rise or a lone fall
	task automatic push_pulse(input logic [TICK_IN_W-1:0] width, input bit glitch);
		logic [TICK_IN_W-1:0] rise_at;
		bit                   extra_rise;
		rise_at = tick_cursor;
		extra_rise = glitch && $urandom_range(0, 1);
		push_word(REQ_EDGE, 1'b1, rise_at);
		if (extra_rise)
			push_word(REQ_EDGE, 1'b1, rise_at + (width >> 1));
		tick_cursor = rise_at + width;
		push_word(REQ_EDGE, 1'b0, tick_cursor);
		tick_cursor = tick_cursor + $urandom_range(20, 60);
		if (glitch && !extra_rise)
			push_word(REQ_EDGE, 1'b0, tick_cursor);
	endtask

	task automatic push_frame(input bit good, input int n_bits, input bit glitchy);
		logic [BYTE_W-1:0]     b0, b1, b2, b3, sum;
		logic [FRAME_BITS-1:0] bits;
		push_word(REQ_START, 1'($urandom), $urandom);
		// land some replies right on the tick wrap
		tick_cursor = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
			: $urandom;
		if ($urandom_range(0, 3) == 0)
			push_pulse($urandom_range(0, thresholds.sof_min), 1'b0);
		push_pulse(TICK_IN_W'(thresholds.sof_min) + 1 + $urandom_range(0, 200), 1'b0);
		b0 = $urandom;
		b1 = $urandom;
		b2 = $urandom;
		b3 = $urandom;
		sum = b0 + b1 + b2 + b3;
		bits = {b0, b1, b2, b3, good ? sum : sum ^ 8'($urandom_range(1, 255))};
		for (int i = 0; i < n_bits; i++)
			push_pulse(bits[FRAME_BITS-1-i] ? one_width() : zero_width(),
				glitchy && ($urandom_range(0, 9) == 0));
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_SOF_MIN: thresholds.sof_min = value;
			CFG_ONE_MIN: thresholds.one_min = value;
			default: thresholds.one_max = value;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// check at the rising edge, where the driver's last update has settled
	task automatic wait_idle();
		@(posedge clk);
		while (pending_words.size() > 0 || in_valid || expected_readings.size() > 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	logic [CFG_W-1:0] sof_set [6] = '{16'd80, 16'd0, 16'd65535, 16'd100, 16'd0, 16'd80};
	logic [CFG_W-1:0] min_set [6] = '{16'd60, 16'd0, 16'd65534, 16'd300, 16'd0, 16'd60};
	logic [CFG_W-1:0] max_set [6] = '{16'd80, 16'd65535, 16'd65535, 16'd100, 16'd0, 16'd80};

	initial begin
		int unsigned phase_goal;
		int unsigned pick;
		thresholds.sof_min = SOF_MIN_RST;
		thresholds.one_min = ONE_MIN_RST;
		thresholds.one_max = ONE_MAX_RST;
		dec_phase = PH_DONE;
		dec_rise_seen = 1'b0;
		dec_rise_tick = '0;
		dec_bit_count = '0;
		dec_frame = '0;
		dec_temp = '0;
		dec_humid = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: edges while done, ignored edges, start, wrap, bit window edges
		push_word(REQ_EDGE, 1'b0, 32'h0000_0000);
		push_word(REQ_EDGE, 1'b1, 32'hFFFF_FFFF);
		push_word(REQ_EDGE, 1'b0, 32'h0000_0050);
		push_word(REQ_EDGE, 1'b1, 32'h0000_0000);
		push_word(REQ_EDGE, 1'b1, 32'h0000_0064);
		push_word(REQ_EDGE, 1'b0, 32'h0000_00C8);
		push_word(REQ_START, 1'b1, 32'hFFFF_FFFF);
		push_word(REQ_START, 1'b0, 32'h0000_0000);
		push_word(REQ_EDGE, 1'b1, 32'h0000_03E8);
		push_word(REQ_EDGE, 1'b0, 32'h0000_0438);
		push_word(REQ_EDGE, 1'b0, 32'h0000_0500);
		tick_cursor = 32'hFFFF_FFE0;
		push_pulse(32'd81, 1'b0);
		push_pulse(32'd60, 1'b0);
		push_pulse(32'd61, 1'b0);
		push_pulse(32'd79, 1'b0);
		push_pulse(32'd80, 1'b0);
		push_pulse(32'd0, 1'b0);
		push_word(REQ_START, 1'b1, 32'h5555_AAAA);
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				write_reg(CFG_SOF_MIN, (ph == 4) ? CFG_W'($urandom_range(0, 200)) : sof_set[ph]);
				write_reg(CFG_ONE_MIN, (ph == 4) ? CFG_W'($urandom_range(0, 100)) : min_set[ph]);
				write_reg(CFG_ONE_MAX, (ph == 4) ? thresholds.one_min + CFG_W'($urandom_range(2, 100))
					: max_set[ph]);
			end
			calm = (ph == 2) || ($urandom_range(0, 3) == 0);
			phase_goal = pushed_words + PHASE_WORDS;
			while (pushed_words < phase_goal) begin
				pick = $urandom_range(0, 99);
				if (pick < 65)
					push_frame($urandom_range(0, 3) != 0, FRAME_BITS, 1'b0);
				else if (pick < 78)
					push_frame($urandom_range(0, 1), FRAME_BITS, 1'b1);
				else if (pick < 88)
					push_frame(1'b1, $urandom_range(0, FRAME_BITS - 1), 1'b0);
				else if (pick < 94)
					repeat (8) push_word(($urandom_range(0, 7) != 0) ? REQ_EDGE : REQ_START,
						1'($urandom), $urandom);
				else
					repeat (3) push_pulse(one_width(), 1'b1);
			end
			// hold the sender until every result is back
			wait_idle();
		end

		repeat (6) @(negedge clk);
		if (failures == 0)
			$display("dht11_pulse_width_decoder_top verification clean");
		else
			$display("dht11_pulse_width_decoder_top verification failed");
		$finish;
	end

endmodule
